// ===== src/tcts_pkg.sv =====
// Shared types and codes for the texture cache tag store.
package tcts_pkg;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_PURGE  = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  localparam logic [1:0] CFG_CHECKSUM_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TABLE_AGE       = 2'd1;
  localparam logic [1:0] CFG_RECYCLE_AGE     = 2'd2;
  localparam logic [1:0] CFG_BUCKET_COUNT    = 2'd3;

  localparam logic [15:0] STAMP_LIMIT = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] tex_address;
    logic [23:0] palette_address;
    logic [11:0] left;
    logic [11:0] top;
    logic [10:0] width;
    logic [10:0] height;
    logic [31:0] checksum;
    logic [31:0] now_ms;
  } tcts_req_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  slot;
    logic        reconvert;
    logic        no_slot;
    logic [31:0] used_checksum;
    logic [5:0]  moved_count;
    logic [5:0]  freed_count;
  } tcts_rsp_t;

  typedef struct packed {
    logic [23:0] tex_address;
    logic [23:0] palette_address;
    logic [11:0] left;
    logic [11:0] top;
    logic [10:0] width;
    logic [10:0] height;
    logic [31:0] sum;
    logic [31:0] last_used;
    logic [31:0] use_count;
  } tcts_slot_data_t;

endpackage

// ===== src/tcts_ram.sv =====
// Single write port, single read port memory with registered read data.
module tcts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/texture_cache_tag_store.sv =====
// Texture cache tag store: control sequencer over the slot, stamp, rank and bucket memories.
//
// Requests arrive on req_valid/req_ready and carry a lookup, a purge or a drop-all.
// One request is worked on at a time; req_ready is high while the sequencer is idle.
// The result is held in an output register on rsp_valid/rsp_ready, so a new request
// can be taken while the previous result waits for the receiver.
// A lookup scans every slot once, reading each slot and then using its data, then
// decides and writes back. Purge and drop first compute a bucket for each table slot
// with a serial divider, then pick entries in bucket order, one full scan of the slots
// per table entry, and purge ends with one more scan of the pool. When the order
// counter reaches 65535, the stamps are renumbered by rank among the live slots and
// the counter restarts at the number of live slots.
// Reset clears the table and pool flags, the order counter and the configuration
// registers to their defaults; the slot memories hold no reset value.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register is free. The user must write configuration through cfg_we
// only while no request is in flight; the block itself does not enforce this.
module texture_cache_tag_store #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tcts_pkg::tcts_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tcts_pkg::tcts_rsp_t rsp,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import tcts_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);
  localparam int DW = $bits(tcts_slot_data_t);

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_L_RD   = 22'h000002,
    S_L_USE  = 22'h000004,
    S_L_DEC  = 22'h000008,
    S_B_RD   = 22'h000010,
    S_B_LD   = 22'h000020,
    S_B_DIV  = 22'h000040,
    S_B_WR   = 22'h000080,
    S_W_RD   = 22'h000100,
    S_W_USE  = 22'h000200,
    S_W_ACT  = 22'h000400,
    S_F_RD   = 22'h000800,
    S_F_USE  = 22'h001000,
    S_STAMP  = 22'h002000,
    S_R_IRD  = 22'h004000,
    S_R_ILAT = 22'h008000,
    S_R_JRD  = 22'h010000,
    S_R_JUSE = 22'h020000,
    S_R_WR   = 22'h040000,
    S_R_CRD  = 22'h080000,
    S_R_CWR  = 22'h100000,
    S_DONE   = 22'h200000
  } state_t;

  state_t state;
  state_t after;

  logic        checksum_enable;
  logic [31:0] table_age_ms;
  logic [31:0] recycle_age_ms;
  logic [15:0] bucket_count;

  tcts_req_t cur;
  tcts_rsp_t res;

  logic [SLOT_COUNT-1:0] in_table;
  logic [SLOT_COUNT-1:0] in_pool;
  logic [SLOT_COUNT-1:0] pending;

  logic [AW-1:0] cnt;
  logic [AW-1:0] ri;
  logic [AW-1:0] rj;
  logic [AW-1:0] tgt;

  logic          mfound;
  logic          pfound;
  logic          ffound;
  logic [AW-1:0] mslot;
  logic [AW-1:0] pslot;
  logic [AW-1:0] fslot;
  logic [31:0]   msum;
  logic [31:0]   mlast;
  logic [31:0]   muse;
  logic [15:0]   pstamp;

  logic          wfound;
  logic [AW-1:0] wslot;
  logic [15:0]   wbucket;
  logic [15:0]   wstamp;
  logic [31:0]   wlast;

  logic [21:0] dvd;
  logic [15:0] rem;
  logic [4:0]  dcnt;

  logic [15:0] stamp_i;
  logic [AW:0] rank;
  logic [AW:0] rn;
  logic [15:0] order_counter;

  logic            data_we;
  logic [AW-1:0]   data_waddr;
  tcts_slot_data_t data_wdata;
  logic [DW-1:0]   data_rdata;
  tcts_slot_data_t data_rd;

  logic          stamp_we;
  logic [AW-1:0] stamp_waddr;
  logic [15:0]   stamp_wdata;
  logic [AW-1:0] stamp_raddr;
  logic [15:0]   stamp_rdata;

  logic [AW:0]   rank_rdata;
  logic [15:0]   bucket_rdata;

  logic          key_eq;
  logic [31:0]   cs_eff;
  logic [31:0]   sum_sel;
  logic          sum_same;
  logic [15:0]   bc_eff;
  logic [16:0]   remsh;
  logic [15:0]   rem_next;
  logic [31:0]   age_w;
  logic [31:0]   age_f;
  logic          w_better;
  logic          live_ri;
  logic          live_rj;
  logic [AW-1:0] tgt_new;

  assign data_rd  = tcts_slot_data_t'(data_rdata);
  assign key_eq   = data_rd.tex_address == cur.tex_address &&
                    data_rd.palette_address == cur.palette_address &&
                    data_rd.left == cur.left && data_rd.top == cur.top &&
                    data_rd.width == cur.width && data_rd.height == cur.height;
  assign cs_eff   = checksum_enable ? cur.checksum : 32'd0;
  assign sum_sel  = (mfound && mlast == cur.now_ms) ? msum : cs_eff;
  assign sum_same = msum == sum_sel;
  assign bc_eff   = (bucket_count == 16'd0) ? 16'd1 : bucket_count;
  assign remsh    = {rem, dvd[21]};
  assign rem_next = (remsh >= {1'b0, bc_eff}) ? 16'(remsh - {1'b0, bc_eff}) : remsh[15:0];
  assign age_w    = cur.now_ms - wlast;
  assign age_f    = cur.now_ms - data_rd.last_used;
  assign w_better = pending[cnt] && (!wfound || bucket_rdata < wbucket ||
                    (bucket_rdata == wbucket && stamp_rdata > wstamp));
  assign live_ri  = in_table[ri] | in_pool[ri];
  assign live_rj  = in_table[rj] | in_pool[rj];
  assign tgt_new  = pfound ? pslot : fslot;

  assign req_ready = state == S_IDLE;

  always_comb begin
    data_wdata.tex_address     = cur.tex_address;
    data_wdata.palette_address = cur.palette_address;
    data_wdata.left            = cur.left;
    data_wdata.top             = cur.top;
    data_wdata.width           = cur.width;
    data_wdata.height          = cur.height;
    data_wdata.sum             = sum_sel;
    if (mfound) begin
      data_wdata.last_used = sum_same ? cur.now_ms : mlast;
      data_wdata.use_count = sum_same ? muse + 32'd1 : muse;
    end else begin
      data_wdata.last_used = cur.now_ms;
      data_wdata.use_count = 32'd0;
    end
  end

  assign data_we     = (state == S_L_DEC) && (mfound || pfound || ffound);
  assign data_waddr  = mfound ? mslot : tgt_new;

  assign stamp_we    = ((state == S_STAMP) && (order_counter != STAMP_LIMIT)) ||
                       (state == S_R_CWR);
  assign stamp_waddr = (state == S_R_CWR) ? ri : tgt;
  assign stamp_wdata = (state == S_R_CWR) ? 16'(rank_rdata) : order_counter;

  always_comb begin
    case (state)
      S_R_IRD: stamp_raddr = ri;
      S_R_JRD: stamp_raddr = rj;
      default: stamp_raddr = cnt;
    endcase
  end

  tcts_ram #(.WIDTH(DW), .DEPTH(SLOT_COUNT)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(cnt), .rdata(data_rdata)
  );

  tcts_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_stamp (
    .clk(clk), .we(stamp_we), .waddr(stamp_waddr), .wdata(stamp_wdata),
    .raddr(stamp_raddr), .rdata(stamp_rdata)
  );

  tcts_ram #(.WIDTH(AW + 1), .DEPTH(SLOT_COUNT)) u_rank (
    .clk(clk), .we(state == S_R_WR), .waddr(ri), .wdata(rank),
    .raddr(ri), .rdata(rank_rdata)
  );

  tcts_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_bucket (
    .clk(clk), .we(state == S_B_WR), .waddr(cnt), .wdata(rem),
    .raddr(cnt), .rdata(bucket_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_enable <= 1'b1;
      table_age_ms    <= 32'd5000;
      recycle_age_ms  <= 32'd30000;
      bucket_count    <= 16'd1021;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHECKSUM_ENABLE: checksum_enable <= cfg_data[0];
        CFG_TABLE_AGE:       table_age_ms    <= cfg_data;
        CFG_RECYCLE_AGE:     recycle_age_ms  <= cfg_data;
        CFG_BUCKET_COUNT:    bucket_count    <= cfg_data[15:0];
        default:             checksum_enable <= checksum_enable;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      after         <= S_DONE;
      in_table      <= '0;
      in_pool       <= '0;
      order_counter <= 16'd0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            res    <= '0;
            cnt    <= '0;
            mfound <= 1'b0;
            pfound <= 1'b0;
            ffound <= 1'b0;
            case (req.kind)
              KIND_LOOKUP: state <= S_L_RD;
              KIND_PURGE, KIND_DROP: begin
                pending <= in_table;
                state   <= S_B_RD;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_L_RD: state <= S_L_USE;
        S_L_USE: begin
          if (in_table[cnt] && key_eq && !mfound) begin
            mfound <= 1'b1;
            mslot  <= cnt;
            msum   <= data_rd.sum;
            mlast  <= data_rd.last_used;
            muse   <= data_rd.use_count;
          end
          if (in_pool[cnt] && data_rd.width == cur.width && data_rd.height == cur.height &&
              (!pfound || stamp_rdata > pstamp)) begin
            pfound <= 1'b1;
            pslot  <= cnt;
            pstamp <= stamp_rdata;
          end
          if (!in_table[cnt] && !in_pool[cnt] && !ffound) begin
            ffound <= 1'b1;
            fslot  <= cnt;
          end
          if (cnt == LAST) begin
            state <= S_L_DEC;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_L_RD;
          end
        end
        S_L_DEC: begin
          if (mfound) begin
            res.slot          <= 5'(mslot);
            res.hit           <= sum_same;
            res.reconvert     <= !sum_same;
            res.used_checksum <= sum_sel;
            state             <= S_DONE;
          end else if (pfound || ffound) begin
            in_pool[tgt_new]  <= 1'b0;
            in_table[tgt_new] <= 1'b1;
            tgt               <= tgt_new;
            res.slot          <= 5'(tgt_new);
            res.reconvert     <= 1'b1;
            res.used_checksum <= sum_sel;
            after             <= S_DONE;
            state             <= S_STAMP;
          end else begin
            res.no_slot <= 1'b1;
            state       <= S_DONE;
          end
        end
        S_B_RD, S_B_WR: begin
          if (state == S_B_RD && in_table[cnt]) begin
            state <= S_B_LD;
          end else if (cnt == LAST) begin
            cnt    <= '0;
            wfound <= 1'b0;
            state  <= S_W_RD;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_B_RD;
          end
        end
        S_B_LD: begin
          dvd   <= data_rd.tex_address[23:2];
          rem   <= 16'd0;
          dcnt  <= 5'd0;
          state <= S_B_DIV;
        end
        S_B_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[20:0], 1'b0};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd21) begin
            state <= S_B_WR;
          end
        end
        S_W_RD: state <= S_W_USE;
        S_W_USE: begin
          if (w_better) begin
            wfound  <= 1'b1;
            wslot   <= cnt;
            wbucket <= bucket_rdata;
            wstamp  <= stamp_rdata;
            wlast   <= data_rd.last_used;
          end
          if (cnt == LAST) begin
            state <= S_W_ACT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_W_RD;
          end
        end
        S_W_ACT: begin
          cnt <= '0;
          if (!wfound) begin
            state <= (cur.kind == KIND_PURGE) ? S_F_RD : S_DONE;
          end else begin
            pending[wslot] <= 1'b0;
            wfound         <= 1'b0;
            if (cur.kind == KIND_DROP || age_w > table_age_ms) begin
              in_table[wslot] <= 1'b0;
              in_pool[wslot]  <= 1'b1;
              res.moved_count <= res.moved_count + 6'd1;
              tgt             <= wslot;
              after           <= S_W_RD;
              state           <= S_STAMP;
            end else begin
              state <= S_W_RD;
            end
          end
        end
        S_F_RD: state <= S_F_USE;
        S_F_USE: begin
          if (in_pool[cnt] && age_f > recycle_age_ms) begin
            in_pool[cnt]    <= 1'b0;
            res.freed_count <= res.freed_count + 6'd1;
          end
          if (cnt == LAST) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_F_RD;
          end
        end
        S_STAMP: begin
          if (order_counter == STAMP_LIMIT) begin
            ri    <= '0;
            rn    <= '0;
            state <= S_R_IRD;
          end else begin
            order_counter <= order_counter + 16'd1;
            cnt           <= '0;
            state         <= after;
          end
        end
        S_R_IRD: begin
          if (live_ri) begin
            state <= S_R_ILAT;
          end else if (ri == LAST) begin
            ri    <= '0;
            state <= S_R_CRD;
          end else begin
            ri <= ri + 1'b1;
          end
        end
        S_R_ILAT: begin
          stamp_i <= stamp_rdata;
          rank    <= '0;
          rj      <= '0;
          state   <= S_R_JRD;
        end
        S_R_JRD: state <= S_R_JUSE;
        S_R_JUSE: begin
          if (live_rj && stamp_rdata < stamp_i) begin
            rank <= rank + 1'b1;
          end
          if (rj == LAST) begin
            state <= S_R_WR;
          end else begin
            rj    <= rj + 1'b1;
            state <= S_R_JRD;
          end
        end
        S_R_WR: begin
          rn <= rn + 1'b1;
          if (ri == LAST) begin
            ri    <= '0;
            state <= S_R_CRD;
          end else begin
            ri    <= ri + 1'b1;
            state <= S_R_IRD;
          end
        end
        S_R_CRD, S_R_CWR: begin
          if (state == S_R_CRD && live_ri) begin
            state <= S_R_CWR;
          end else if (ri == LAST) begin
            order_counter <= 16'(rn);
            state         <= S_STAMP;
          end else begin
            ri    <= ri + 1'b1;
            state <= S_R_CRD;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(|(in_table & in_pool)))
    else $error("A slot is both in the table and in the recycle pool.");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_DIV) |-> (rem < bc_eff))
    else $error("Bucket remainder is not below the bucket count.");

  a_stamp_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_STAMP && order_counter != STAMP_LIMIT) |=>
      (order_counter == $past(order_counter) + 16'd1))
    else $error("Order counter did not advance after a stamp was assigned.");

  a_new_slot_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_L_DEC && !mfound && (pfound || ffound)) |=> in_table[tgt])
    else $error("A newly assigned slot is missing from the table.");

endmodule

// ===== bench/tcts_checker.sv =====
// Watches the request and result channels of the tag store, predicts each result and compares.
module tcts_checker
  import tcts_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  tcts_req_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  tcts_rsp_t rsp,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic            cs_enable;
  logic [31:0]     table_age;
  logic [31:0]     recycle_age;
  logic [15:0]     buckets;
  logic            in_table[SLOTS];
  logic            in_pool[SLOTS];
  tcts_slot_data_t entry[SLOTS];
  logic [15:0]     stamp[SLOTS];
  logic [15:0]     stamp_next;
  tcts_rsp_t       awaited_results[$];

  assign pending = awaited_results.size();

  function automatic logic [15:0] take_stamp();
    int unsigned n;
    logic [15:0] rank[SLOTS];
    if (stamp_next == STAMP_LIMIT) begin
      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
        rank[i] = 0;
        if (in_table[i] || in_pool[i]) begin
          n++;
          for (int j = 0; j < SLOTS; j++)
            if ((in_table[j] || in_pool[j]) && stamp[j] < stamp[i]) rank[i]++;
        end
      end
      for (int i = 0; i < SLOTS; i++)
        if (in_table[i] || in_pool[i]) stamp[i] = rank[i];
      stamp_next = n[15:0];
    end
    take_stamp = stamp_next;
    stamp_next++;
  endfunction

  function automatic int unsigned bucket_of(int s);
    int unsigned bc;
    bc = (buckets == 0) ? 1 : buckets;
    return (entry[s].tex_address >> 2) % bc;
  endfunction

  // Table slots in bucket order, newest first within a bucket.
  function automatic int walk_table(ref int order[SLOTS]);
    logic picked[SLOTS];
    int n;
    int best;
    n = 0;
    for (int i = 0; i < SLOTS; i++) picked[i] = 1'b0;
    forever begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (in_table[i] && !picked[i])
          if (best < 0 || bucket_of(i) < bucket_of(best) ||
              (bucket_of(i) == bucket_of(best) && stamp[i] > stamp[best])) best = i;
      if (best < 0) break;
      picked[best] = 1'b1;
      order[n] = best;
      n++;
    end
    return n;
  endfunction

  function automatic tcts_rsp_t predict_store_result(tcts_req_t r);
    tcts_rsp_t   res;
    int          s;
    int          n;
    int          order[SLOTS];
    logic [31:0] sum;
    logic [5:0]  moved;
    logic [5:0]  freed;
    res = '0;
    s = -1;
    moved = 0;
    freed = 0;
    case (r.kind)
      KIND_LOOKUP: begin
        for (int i = 0; i < SLOTS; i++)
          if (s < 0 && in_table[i] && entry[i].tex_address == r.tex_address &&
              entry[i].palette_address == r.palette_address && entry[i].left == r.left &&
              entry[i].top == r.top && entry[i].width == r.width &&
              entry[i].height == r.height) s = i;
        if (s >= 0 && entry[s].last_used == r.now_ms) sum = entry[s].sum;
        else sum = cs_enable ? r.checksum : 32'd0;
        if (s >= 0) begin
          if (entry[s].sum == sum) begin
            entry[s].use_count++;
            entry[s].last_used = r.now_ms;
            res.hit = 1'b1;
          end else begin
            entry[s].sum = sum;
            res.reconvert = 1'b1;
          end
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (in_pool[i] && entry[i].width == r.width && entry[i].height == r.height &&
                (s < 0 || stamp[i] > stamp[s])) s = i;
          if (s < 0)
            for (int i = 0; i < SLOTS; i++)
              if (s < 0 && !in_table[i] && !in_pool[i]) s = i;
          if (s < 0) begin
            res.no_slot = 1'b1;
            return res;
          end
          in_pool[s] = 1'b0;
          in_table[s] = 1'b1;
          stamp[s] = take_stamp();
          entry[s] = '{r.tex_address, r.palette_address, r.left, r.top, r.width, r.height,
                       sum, r.now_ms, 32'd0};
          res.reconvert = 1'b1;
        end
        res.slot = s[4:0];
        res.used_checksum = entry[s].sum;
      end
      KIND_PURGE: begin
        n = walk_table(order);
        for (int i = 0; i < n; i++)
          if (r.now_ms - entry[order[i]].last_used > table_age) begin
            in_table[order[i]] = 1'b0;
            in_pool[order[i]] = 1'b1;
            stamp[order[i]] = take_stamp();
            moved++;
          end
        for (int i = 0; i < SLOTS; i++)
          if (in_pool[i] && r.now_ms - entry[i].last_used > recycle_age) begin
            in_pool[i] = 1'b0;
            freed++;
          end
        res.moved_count = moved;
        res.freed_count = freed;
      end
      KIND_DROP: begin
        n = walk_table(order);
        for (int i = 0; i < n; i++) begin
          in_table[order[i]] = 1'b0;
          in_pool[order[i]] = 1'b1;
          stamp[order[i]] = take_stamp();
        end
        res.moved_count = n[5:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cs_enable <= 1'b1;
      table_age <= 32'd5000;
      recycle_age <= 32'd30000;
      buckets <= 16'd1021;
      stamp_next <= '0;
      fail_count <= 0;
      for (int i = 0; i < SLOTS; i++) begin
        in_table[i] <= 1'b0;
        in_pool[i] <= 1'b0;
      end
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHECKSUM_ENABLE: cs_enable <= cfg_data[0];
          CFG_TABLE_AGE:       table_age <= cfg_data;
          CFG_RECYCLE_AGE:     recycle_age <= cfg_data;
          CFG_BUCKET_COUNT:    buckets <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result %p", rsp);
          fail_count <= fail_count + 1;
        end else begin
          if (rsp !== awaited_results[0]) begin
            if (fail_count < 10)
              $display("Result mismatch: expected %p, got %p", awaited_results[0], rsp);
            fail_count <= fail_count + 1;
          end
          void'(awaited_results.pop_front());
        end
      end
      if (req_valid && req_ready) awaited_results.push_back(predict_store_result(req));
    end
  end
endmodule

// ===== bench/texture_cache_tag_store_tb.sv =====
// Stimulus, reset and verdict for the texture cache tag store.
module texture_cache_tag_store_tb
  import tcts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 20_000_000;
  localparam int KEYS = 48;
  localparam int REQ_W = $bits(tcts_req_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  tcts_req_t   req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  tcts_rsp_t   rsp;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  logic [31:0] now = 0;
  tcts_req_t   key_pool[KEYS];

  texture_cache_tag_store dut (.*);

  tcts_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    logic ready;
    case ((cycles / 300) % 3)
      0: ready = 1'b1;
      1: ready = $urandom_range(0, 1);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          ready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 30);
          ready = 1'b0;
        end else begin
          ready = 1'b1;
        end
      end
    endcase
    rsp_ready <= ready;
  end

  task automatic send_request(tcts_req_t r);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic write_settings(logic [31:0] en, logic [31:0] tage, logic [31:0] rage,
                                logic [31:0] bc);
    req_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHECKSUM_ENABLE;
    cfg_data <= en;
    @(negedge clk);
    cfg_index <= CFG_TABLE_AGE;
    cfg_data <= tage;
    @(negedge clk);
    cfg_index <= CFG_RECYCLE_AGE;
    cfg_data <= rage;
    @(negedge clk);
    cfg_index <= CFG_BUCKET_COUNT;
    cfg_data <= bc;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic tcts_req_t make_request(logic [1:0] k, logic [23:0] a, logic [23:0] p,
                                             logic [11:0] l, logic [11:0] t, logic [10:0] w,
                                             logic [10:0] h, logic [31:0] cs,
                                             logic [31:0] ms);
    return '{k, a, p, l, t, w, h, cs, ms};
  endfunction

  function automatic tcts_req_t random_request();
    tcts_req_t r;
    int        pick;
    int        k;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 2) != 0) now = now + $urandom_range(1, 400);
    if ($urandom_range(0, 49) == 0) now = now + $urandom;
    if (pick < 5) begin
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.kind = KIND_LOOKUP;
      return r;
    end
    if (pick < 11) return make_request(KIND_PURGE, 0, 0, 0, 0, 0, 0, 0, now);
    if (pick < 12) return make_request(KIND_DROP, 0, 0, 0, 0, 0, 0, 0, now);
    if (pick < 13) return make_request(2'd3, 0, 0, 0, 0, 0, 0, 0, now);
    k = $urandom_range(0, KEYS - 1);
    if ($urandom_range(0, 4) == 0) key_pool[k].checksum = $urandom_range(0, 3);
    r = key_pool[k];
    r.now_ms = now;
    return r;
  endfunction

  initial begin
    logic [10:0] sizes[3] = '{11'd1, 11'd16, 11'd1024};
    for (int i = 0; i < KEYS; i++)
      key_pool[i] = make_request(KIND_LOOKUP, 24'($urandom), 24'($urandom), 12'($urandom),
                                 12'($urandom), sizes[$urandom_range(0, 2)],
                                 sizes[$urandom_range(0, 2)], $urandom_range(0, 3), 0);
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    write_settings(1, 5000, 30000, 1021);

    send_request(make_request(KIND_LOOKUP, 0, 0, 0, 0, 1, 1, 0, 0));
    send_request(make_request(KIND_LOOKUP, 0, 0, 0, 0, 1, 1, 5, 0));
    send_request(make_request(KIND_LOOKUP, 0, 0, 0, 0, 1, 1, 0, 10));
    send_request(make_request(KIND_LOOKUP, 0, 0, 0, 0, 1, 1, 7, 20));
    send_request(make_request(KIND_LOOKUP, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF, 1024,
                              1024, 32'hFFFFFFFF, 30));
    send_request(make_request(KIND_PURGE, 0, 0, 0, 0, 0, 0, 0, 30));
    send_request(make_request(KIND_PURGE, 0, 0, 0, 0, 0, 0, 0, 6000));
    send_request(make_request(KIND_LOOKUP, 4, 1, 2, 3, 1, 1, 9, 6000));
    send_request(make_request(KIND_LOOKUP, 8, 1, 2, 3, 1024, 1024, 9, 6000));
    send_request(make_request(KIND_LOOKUP, 4, 1, 2, 3, 1, 1, 9, 6000));
    send_request(make_request(KIND_DROP, 0, 0, 0, 0, 0, 0, 0, 6001));
    send_request(make_request(KIND_PURGE, 0, 0, 0, 0, 0, 0, 0, 40000));
    send_request(make_request(2'd3, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 40001));
    send_request(make_request(KIND_LOOKUP, 12, 0, 0, 0, 2047, 0, 1, 32'hFFFFFFFF));
    send_request(make_request(KIND_PURGE, 0, 0, 0, 0, 0, 0, 0, 32'h1000));
    for (int i = 0; i < 34; i++)
      send_request(make_request(KIND_LOOKUP, 24'(i * 4), 0, 0, 0, 2, 2, 0, 32'h2000));
    send_request(make_request(KIND_DROP, 0, 0, 0, 0, 0, 0, 0, 32'h2000));
    now = 32'h2000;

    write_settings(1, 2000, 10000, 1);
    repeat (160) send_request(random_request());
    write_settings(0, 0, 0, 0);
    repeat (160) send_request(random_request());
    write_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 65521);
    repeat (160) send_request(random_request());
    write_settings(1, 3000, 8000, 32'hABCD0007);
    repeat (160) send_request(random_request());
    write_settings(32'hFFFFFFFE, 1000, 32'hFFFFFFFF, 65535);
    repeat (160) send_request(random_request());

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/tcts_pkg.sv
src/tcts_ram.sv
src/texture_cache_tag_store.sv
bench/tcts_checker.sv
bench/texture_cache_tag_store_tb.sv
